// ===== hw/rtl/spanning_tree_port_state_engine_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SPANNING_TREE_PORT_STATE_ENGINE_ASSERT_SVH
`define SPANNING_TREE_PORT_STATE_ENGINE_ASSERT_SVH

// Checked only while out of reset.
`define STP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define STP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/stp_pkg.sv =====
`timescale 1ns / 1ps

package stp_pkg;

    // Port count of the bridge and of the neighbor table.
    localparam int PORTS       = 8;
    localparam int TABLE_PORTS = 8;
    localparam int LIVE_CAP    = (PORTS < TABLE_PORTS) ? PORTS : TABLE_PORTS;

    // Queue between front and back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [6:0] HOP_LIMIT = 7'd99;

    // Item kinds
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_CONFIG  = 2'd1;
    localparam logic [1:0] ACT_DATA    = 2'd2;
    localparam logic [1:0] ACT_POLL    = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_OWN_ID    = 2'd0;
    localparam logic [1:0] REG_NBR_TABLE = 2'd1;
    localparam logic [1:0] REG_PORTS_USE = 2'd2;

    typedef struct packed {
        logic [3:0]  own_id;
        logic [31:0] nbr_table;
        logic [3:0]  ports_in_use;
    } cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [1:0] action;
        logic [2:0] port;
        logic [3:0] adv_root;
        logic [6:0] adv_hops;
        logic [6:0] hop_sat;
        logic [3:0] sid;
        logic       port_live;
        logic [7:0] live_mask;
        logic       own_match;
        logic       src_match;
    } cmd_t;

    typedef struct packed {
        logic [3:0] root_now;
        logic [6:0] hops_now;
        logic       has_parent;
        logic [3:0] parent_now;
        logic [7:0] data_open_mask;
        logic [7:0] config_open_mask;
        logic       announce;
        logic       deliver_local;
        logic [7:0] relay_mask;
    } res_t;

endpackage

// ===== hw/rtl/stp_front.sv =====
`timescale 1ns / 1ps

module stp_front (
    input  stp_pkg::cfg_t  cfg,
    input  logic [1:0]     action,
    input  logic [2:0]     port,
    input  logic [3:0]     advertised_root,
    input  logic [6:0]     advertised_hops,
    input  logic [3:0]     frame_source,
    input  logic [3:0]     frame_dest,
    output stp_pkg::cmd_t  cmd
);
    import stp_pkg::*;

    logic [3:0] live_cnt;
    logic [7:0] hop_inc;
    logic [3:0] sid;

    // live port count: register value capped by the table size
    always_comb begin
        if (cfg.ports_in_use > 4'(LIVE_CAP)) begin
            live_cnt = 4'(LIVE_CAP);
        end else begin
            live_cnt = cfg.ports_in_use;
        end
    end

    assign hop_inc = {1'b0, advertised_hops} + 8'd1;
    assign sid     = cfg.nbr_table[{port, 2'b00} +: 4];

    always_comb begin
        cmd.action    = action;
        cmd.port      = port;
        cmd.adv_root  = advertised_root;
        cmd.adv_hops  = advertised_hops;
        cmd.hop_sat   = (hop_inc > {1'b0, HOP_LIMIT}) ? HOP_LIMIT : hop_inc[6:0];
        cmd.sid       = sid;
        cmd.port_live = ({1'b0, port} < live_cnt);
        cmd.own_match = (frame_dest == cfg.own_id);
        cmd.src_match = (frame_source == sid);
        for (int i = 0; i < TABLE_PORTS; i++) begin
            cmd.live_mask[i] = (4'(i) < live_cnt);
        end
    end

endmodule

// ===== hw/rtl/stp_queue.sv =====
`timescale 1ns / 1ps

module stp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  stp_pkg::cmd_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output stp_pkg::cmd_t  rd_data
);
    import stp_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign wr_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/stp_back.sv =====
`timescale 1ns / 1ps

module stp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  stp_pkg::cfg_t  cfg,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  stp_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output stp_pkg::res_t  res
);
    import stp_pkg::*;

    logic [3:0] root_reg, root_next;
    logic [6:0] hop_reg, hop_next;
    logic       pv_reg, pv_next;
    logic [3:0] pid_reg, pid_next;
    logic [7:0] data_open_reg, data_open_next;
    logic [7:0] cfg_open_reg, cfg_open_next;
    logic       chg_reg, chg_next;
    logic       out_valid_reg;
    res_t       out_reg, out_next;

    logic       fire;
    logic [7:0] nbr_is_sid;
    logic [7:0] nbr_is_parent;
    logic [7:0] restart_mask;
    logic [7:0] port_bit;
    logic       deliver;
    logic [7:0] relay;
    logic       better;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // per-port neighbor compares
    always_comb begin
        for (int i = 0; i < TABLE_PORTS; i++) begin
            nbr_is_sid[i]    = (cfg.nbr_table[i*4 +: 4] == cmd.sid);
            nbr_is_parent[i] = (cfg.nbr_table[i*4 +: 4] == pid_reg);
            restart_mask[i]  = (i < LIVE_CAP);
        end
    end

    assign port_bit = 8'd1 << cmd.port;
    assign better   = (cmd.adv_root < root_reg) ||
                      ((cmd.adv_root == root_reg) && (cmd.hop_sat < hop_reg));

    // state update for one word
    always_comb begin
        root_next      = root_reg;
        hop_next       = hop_reg;
        pv_next        = pv_reg;
        pid_next       = pid_reg;
        data_open_next = data_open_reg;
        cfg_open_next  = cfg_open_reg;
        chg_next       = chg_reg;
        deliver        = 1'b0;
        relay          = '0;
        case (cmd.action)
            ACT_RESTART: begin
                root_next      = cfg.own_id;
                hop_next       = '0;
                pv_next        = 1'b0;
                pid_next       = '0;
                data_open_next = '0;
                cfg_open_next  = restart_mask;
                chg_next       = 1'b1;
            end
            ACT_CONFIG: begin
                if (cmd.port_live) begin
                    if (pv_reg && (cmd.sid == pid_reg)) begin
                        // message from the parent
                        if (!((cmd.hop_sat == hop_reg) && (cmd.adv_root == root_reg))) begin
                            root_next = cmd.adv_root;
                            hop_next  = cmd.hop_sat;
                            chg_next  = 1'b1;
                        end
                    end else if (better) begin
                        // adopt sender as parent, close ports toward old parent
                        if (cmd.adv_root < root_reg) begin
                            root_next = cmd.adv_root;
                        end
                        if (pv_reg) begin
                            data_open_next = data_open_next & ~(nbr_is_parent & cmd.live_mask);
                            cfg_open_next  = cfg_open_next & ~(nbr_is_parent & cmd.live_mask);
                        end
                        pv_next        = 1'b1;
                        pid_next       = cmd.sid;
                        hop_next       = cmd.hop_sat;
                        data_open_next = data_open_next | port_bit;
                        cfg_open_next  = cfg_open_next & ~port_bit;
                        chg_next       = 1'b1;
                    end else begin
                        // set arrival port role
                        if (cmd.adv_root > root_reg) begin
                            data_open_next = data_open_next | port_bit;
                            cfg_open_next  = cfg_open_next | port_bit;
                        end else if (hop_reg == cmd.adv_hops) begin
                            if (cfg.own_id < cmd.sid) begin
                                data_open_next = data_open_next & ~port_bit;
                                cfg_open_next  = cfg_open_next | port_bit;
                            end else if (cfg.own_id > cmd.sid) begin
                                data_open_next = data_open_next & ~port_bit;
                                cfg_open_next  = cfg_open_next & ~port_bit;
                            end
                        end else if (hop_reg < cmd.adv_hops) begin
                            data_open_next = data_open_next | port_bit;
                            cfg_open_next  = cfg_open_next | port_bit;
                        end else begin
                            data_open_next = data_open_next & ~port_bit;
                            cfg_open_next  = cfg_open_next & ~port_bit;
                        end
                        // root bridge opens every live port
                        if (root_reg == cfg.own_id) begin
                            data_open_next = data_open_next | cmd.live_mask;
                            cfg_open_next  = cfg_open_next | cmd.live_mask;
                            chg_next       = 1'b0;
                        end
                    end
                end
            end
            ACT_DATA: begin
                if (cmd.port_live) begin
                    if (cmd.own_match) begin
                        deliver = cmd.src_match || data_open_reg[cmd.port];
                    end else if (data_open_reg[cmd.port]) begin
                        relay = data_open_reg & cmd.live_mask & ~nbr_is_sid;
                    end
                end
            end
            ACT_POLL: begin
                chg_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // result built from the updated state
    always_comb begin
        out_next.root_now         = root_next;
        out_next.hops_now         = hop_next;
        out_next.has_parent       = pv_next;
        out_next.parent_now       = pv_next ? pid_next : 4'd0;
        out_next.data_open_mask   = data_open_next;
        out_next.config_open_mask = cfg_open_next;
        out_next.announce         = (cmd.action == ACT_POLL) ? chg_reg : chg_next;
        out_next.deliver_local    = deliver;
        out_next.relay_mask       = relay;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg      <= '0;
            hop_reg       <= '0;
            pv_reg        <= 1'b0;
            pid_reg       <= '0;
            data_open_reg <= '0;
            cfg_open_reg  <= restart_mask;
            chg_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                root_reg      <= root_next;
                hop_reg       <= hop_next;
                pv_reg        <= pv_next;
                pid_reg       <= pid_next;
                data_open_reg <= data_open_next;
                cfg_open_reg  <= cfg_open_next;
                chg_reg       <= chg_next;
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hw/rtl/spanning_tree_port_state_engine.sv =====
// Path: an accepted word passes the queue and then the back end's output register to m_tvalid.
// Throughput: one word per cycle while m_tready is high; the back end updates all port state
// for each word, and a two-entry queue plus the output register absorb up to three words of
// back-pressure. Reset: synchronous, active low; registers return to defaults, the queue
// empties and the tree state restarts with this bridge as root and announce pending.
`timescale 1ns / 1ps

module spanning_tree_port_state_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [stp_pkg::ADDR_W-1:0] paddr,
    input  logic [stp_pkg::DATA_W-1:0] pwdata,
    output logic [stp_pkg::DATA_W-1:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // port[2:0], advertised_root[6:3], advertised_hops[13:7],
    // frame_source[17:14], frame_dest[21:18], zero pad[23:22]
    input  logic [23:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // root_now[3:0], hops_now[10:4], has_parent[11], parent_now[15:12],
    // data_open_mask[23:16], config_open_mask[31:24], announce[32],
    // deliver_local[33], relay_mask[41:34], zero pad[47:42]
    output logic [47:0] m_tdata
);
    import stp_pkg::*;

    logic [3:0]  own_id_reg;
    logic [31:0] nbr_table_reg;
    logic [3:0]  ports_use_reg;
    logic        cfg_wr;
    cfg_t        cfg;
    cmd_t        front_cmd;
    cmd_t        q_cmd;
    logic        q_valid, q_ready;
    res_t        res;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg    <= '0;
            nbr_table_reg <= '0;
            ports_use_reg <= 4'(TABLE_PORTS);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OWN_ID:    own_id_reg    <= pwdata[3:0];
                REG_NBR_TABLE: nbr_table_reg <= pwdata;
                REG_PORTS_USE: ports_use_reg <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OWN_ID:    prdata = {28'd0, own_id_reg};
            REG_NBR_TABLE: prdata = nbr_table_reg;
            REG_PORTS_USE: prdata = {28'd0, ports_use_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.own_id       = own_id_reg;
    assign cfg.nbr_table    = nbr_table_reg;
    assign cfg.ports_in_use = ports_use_reg;

    // front: classify incoming word
    stp_front u_front (
        .cfg             (cfg),
        .action          (s_tuser),
        .port            (s_tdata[2:0]),
        .advertised_root (s_tdata[6:3]),
        .advertised_hops (s_tdata[13:7]),
        .frame_source    (s_tdata[17:14]),
        .frame_dest      (s_tdata[21:18]),
        .cmd             (front_cmd)
    );

    stp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    // back: apply to tree state
    stp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'd0, res.relay_mask, res.deliver_local, res.announce,
                      res.config_open_mask, res.data_open_mask, res.parent_now,
                      res.has_parent, res.hops_now, res.root_now};

endmodule

// ===== hw/rtl/stp_checker.sv =====
`timescale 1ns / 1ps
`include "spanning_tree_port_state_engine_assert.svh"

module stp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import stp_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 2);

    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // words accepted but not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `STP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")
    `STP_ASSERT(a_no_invented, !m_tvalid || (inflight_reg != '0), "result word without an accepted input word")
    `STP_ASSERT(a_inflight_cap, inflight_reg <= CNT_W'(QDEPTH + 1), "more words in flight than storage")
    `STP_ASSERT(a_root_hops, m_tvalid && !m_tdata[11] |-> (m_tdata[10:4] == 7'd0) && (m_tdata[15:12] == 4'd0), "no parent but nonzero hop count or parent id")
    `STP_ASSERT_ALWAYS(a_hop_limit, !aresetn || !m_tvalid || (m_tdata[10:4] <= HOP_LIMIT), "hop count beyond limit")

endmodule

bind spanning_tree_port_state_engine stp_checker u_stp_checker (.*);

// ===== bench/spanning_tree_port_state_engine_tb.sv =====
`timescale 1ns / 1ps

module spanning_tree_port_state_engine_tb;
    import stp_pkg::*;

    // Bridge state tracker: mirrors the tree state and queues the expected result words
    class tree_scoreboard;
        logic [3:0]  own_id;
        logic [31:0] nbr_table;
        logic [3:0]  ports_reg;
        logic [3:0]  root_id;
        logic [6:0]  tree_hops;
        logic        parent_valid;
        logic [3:0]  parent_id;
        logic [7:0]  data_open;
        logic [7:0]  config_open;
        logic        announce_pending;
        res_t        expected_q[$];
        int          err_count;

        function new();
            own_id    = 4'd0;
            nbr_table = 32'd0;
            ports_reg = 4'd8;
            err_count = 0;
            restart_tree();
        endfunction

        function int live_ports();
            return (int'(ports_reg) > LIVE_CAP) ? LIVE_CAP : int'(ports_reg);
        endfunction

        function logic [7:0] live_mask(int n);
            return 8'((1 << n) - 1);
        endfunction

        function logic [3:0] nbr(int p);
            return nbr_table[p*4 +: 4];
        endfunction

        function void set_port(int p, bit dat, bit cfg);
            data_open[p]   = dat;
            config_open[p] = cfg;
        endfunction

        function void restart_tree();
            root_id          = own_id;
            tree_hops        = 7'd0;
            parent_valid     = 1'b0;
            parent_id        = 4'd0;
            data_open        = 8'd0;
            config_open      = live_mask(LIVE_CAP);
            announce_pending = 1'b1;
        endfunction

        // New parent: close every live port toward the old one, open the arrival port for data
        function void adopt_parent(int p, logic [3:0] sid, int hop, int n);
            announce_pending = 1'b1;
            if (parent_valid) begin
                for (int i = 0; i < n; i++)
                    if (nbr(i) == parent_id) set_port(i, 1'b0, 1'b0);
            end
            parent_valid = 1'b1;
            parent_id    = sid;
            tree_hops    = 7'(hop);
            set_port(p, 1'b1, 1'b0);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_OWN_ID:    own_id    = val[3:0];
                REG_NBR_TABLE: nbr_table = val;
                REG_PORTS_USE: ports_reg = val[3:0];
                default: ;
            endcase
        endfunction

        // Accepted input word: advance the tree state, queue the result it produces
        function void note_word(logic [1:0] action, logic [23:0] word);
            logic [2:0] p;
            logic [3:0] yr;
            logic [6:0] yh;
            logic [3:0] src;
            logic [3:0] dst;
            logic [3:0] sid;
            int         hop;
            int         n;
            logic       deliver;
            logic       ann;
            logic [7:0] relay;
            res_t       e;

            p       = word[2:0];
            yr      = word[6:3];
            yh      = word[13:7];
            src     = word[17:14];
            dst     = word[21:18];
            n       = live_ports();
            sid     = nbr(p);
            deliver = 1'b0;
            relay   = 8'd0;
            hop     = (int'(yh) + 1 > int'(HOP_LIMIT)) ? int'(HOP_LIMIT) : int'(yh) + 1;

            case (action)
                ACT_RESTART: begin
                    restart_tree();
                end
                ACT_CONFIG: begin
                    if (p < n) begin
                        if (parent_valid && sid == parent_id) begin
                            // parent refresh; saturated hop counts as unchanged
                            if (!(hop == int'(tree_hops) && root_id == yr)) begin
                                root_id          = yr;
                                tree_hops        = 7'(hop);
                                announce_pending = 1'b1;
                            end
                        end else if (yr < root_id) begin
                            root_id = yr;
                            adopt_parent(p, sid, hop, n);
                        end else if (yr == root_id && hop < int'(tree_hops)) begin
                            adopt_parent(p, sid, hop, n);
                        end else begin
                            if (yr == root_id) begin
                                if (tree_hops == yh) begin
                                    if (own_id < sid)      set_port(p, 1'b0, 1'b1);
                                    else if (own_id > sid) set_port(p, 1'b0, 1'b0);
                                end else if (tree_hops < yh) begin
                                    set_port(p, 1'b1, 1'b1);
                                end else begin
                                    set_port(p, 1'b0, 1'b0);
                                end
                            end else begin
                                set_port(p, 1'b1, 1'b1);
                            end
                            // still root: open every live port, nothing to announce
                            if (root_id == own_id) begin
                                data_open        |= live_mask(n);
                                config_open      |= live_mask(n);
                                announce_pending  = 1'b0;
                            end
                        end
                    end
                end
                ACT_DATA: begin
                    if (p < n) begin
                        if (dst == own_id) begin
                            deliver = (src == sid) || data_open[p];
                        end else if (data_open[p]) begin
                            for (int i = 0; i < n; i++)
                                if (data_open[i] && nbr(i) != sid) relay[i] = 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // poll reports the flag as it was, then clears it
            ann = announce_pending;
            if (action == ACT_POLL) announce_pending = 1'b0;

            e.root_now         = root_id;
            e.hops_now         = tree_hops;
            e.has_parent       = parent_valid;
            e.parent_now       = parent_valid ? parent_id : 4'd0;
            e.data_open_mask   = data_open;
            e.config_open_mask = config_open;
            e.announce         = ann;
            e.deliver_local    = deliver;
            e.relay_mask       = relay;
            expected_q.insert(expected_q.size(), e);
        endfunction

        function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
                err_count++;
            end
        endfunction

        function void check_result(logic [47:0] word);
            res_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, word);
                err_count++;
                return;
            end
            e = expected_q.pop_front();
            cmp_field("root_now",         e.root_now,         word[3:0]);
            cmp_field("hops_now",         e.hops_now,         word[10:4]);
            cmp_field("has_parent",       e.has_parent,       word[11]);
            cmp_field("parent_now",       e.parent_now,       word[15:12]);
            cmp_field("data_open_mask",   e.data_open_mask,   word[23:16]);
            cmp_field("config_open_mask", e.config_open_mask, word[31:24]);
            cmp_field("announce",         e.announce,         word[32]);
            cmp_field("deliver_local",    e.deliver_local,    word[33]);
            cmp_field("relay_mask",       e.relay_mask,       word[41:34]);
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // port[2:0], advertised_root[6:3], advertised_hops[13:7],
    // frame_source[17:14], frame_dest[21:18], zero pad[23:22]
    logic [23:0]         s_tdata  = '0;
    // action[1:0]
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // root_now[3:0], hops_now[10:4], has_parent[11], parent_now[15:12],
    // data_open_mask[23:16], config_open_mask[31:24], announce[32],
    // deliver_local[33], relay_mask[41:34], zero pad[47:42]
    logic [47:0]         m_tdata;

    tree_scoreboard sb = new();
    bit tx_idle      = 1'b0;
    bit rx_stalls    = 1'b0;
    bit hold_off_req = 1'b0;

    spanning_tree_port_state_engine i_dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Monitors: note accepted input words, check accepted result words
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result sink: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (80) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // APB write: setup cycle, then access cycle; the register updates at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input logic [1:0] action, input logic [2:0] port,
                             input logic [3:0] root, input logic [6:0] hops,
                             input logic [3:0] src, input logic [3:0] dst);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {2'b00, dst, src, hops, root, port};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait until every expected word has come back, then let the pipe go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Neighbor ids all in the usual 0..9 range, duplicates likely
    function automatic logic [31:0] random_table();
        logic [31:0] t;
        for (int i = 0; i < 8; i++) t[i*4 +: 4] = 4'($urandom_range(0, 9));
        return t;
    endfunction

    // Random traffic: mostly config and data messages on live ports
    task automatic run_phase(input int count, input bit allow_idle);
        logic [1:0] action;
        logic [2:0] port;
        logic [3:0] root;
        logic [6:0] hops;
        logic [3:0] src;
        logic [3:0] dst;
        int         pick;
        int         n;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                tx_idle   = allow_idle && ($urandom_range(0, 3) != 0);
                rx_stalls = allow_idle && ($urandom_range(0, 3) != 0);
            end
            n    = sb.live_ports();
            pick = $urandom_range(0, 99);
            action = (pick < 4)  ? ACT_RESTART :
                     (pick < 50) ? ACT_CONFIG  :
                     (pick < 85) ? ACT_DATA    : ACT_POLL;
            port = (n == 0 || $urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                          : 3'($urandom_range(0, n - 1));
            root = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 9));
            pick = $urandom_range(0, 9);
            hops = (pick == 0) ? 7'($urandom_range(95, 127)) :
                   (pick < 7)  ? 7'($urandom_range(0, 12))   : 7'($urandom_range(0, 99));
            src  = $urandom_range(0, 1) ? sb.nbr(port) : 4'($urandom_range(0, 15));
            dst  = ($urandom_range(0, 2) == 0) ? sb.own_id : 4'($urandom_range(0, 15));
            send_word(action, port, root, hops, src, dst);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle   = 1'b1;
        rx_stalls = 1'b1;

        // Directed: own id 5; neighbors port0..7 = 6,2,0,7,3,3,1,2
        write_reg(REG_OWN_ID, 32'd5);
        write_reg(REG_NBR_TABLE, 32'h2133_7026);
        send_word(ACT_RESTART, 3'd0, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_POLL,    3'd0, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_POLL,    3'd7, 4'd0, 7'd0, 4'd0, 4'd0);
        // better root from neighbor 2, then a repeat that changes nothing
        send_word(ACT_CONFIG,  3'd1, 4'd2, 7'd3, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd1, 4'd2, 7'd3, 4'd0, 4'd0);
        // parent at the hop limit, then again with a count that saturates the same
        send_word(ACT_CONFIG,  3'd7, 4'd2, 7'd127, 4'd0, 4'd0);
        send_word(ACT_POLL,    3'd0, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd7, 4'd2, 7'd98, 4'd0, 4'd0);
        // root 0 via neighbor 0: ports toward old parent close
        send_word(ACT_CONFIG,  3'd2, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd3, 4'd0, 7'd5, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd4, 4'd0, 7'd1, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd0, 4'd0, 7'd1, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd5, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd6, 4'd9, 7'd0, 4'd0, 4'd0);
        // data: delivery by open port, by direct neighbor, refused, relayed
        send_word(ACT_DATA,    3'd2, 4'd0, 7'd0, 4'd0, 4'd5);
        send_word(ACT_DATA,    3'd4, 4'd0, 7'd0, 4'd3, 4'd5);
        send_word(ACT_DATA,    3'd4, 4'd0, 7'd0, 4'd9, 4'd5);
        send_word(ACT_DATA,    3'd3, 4'd0, 7'd0, 4'd1, 4'd8);
        send_word(ACT_DATA,    3'd4, 4'd0, 7'd0, 4'd1, 4'd8);
        send_word(ACT_DATA,    3'd6, 4'd15, 7'd127, 4'd15, 4'd15);
        send_word(ACT_POLL,    3'd0, 4'd0, 7'd0, 4'd0, 4'd0);
        // back to root: config messages that do not beat it reopen all live ports
        send_word(ACT_RESTART, 3'd0, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd0, 4'd15, 7'd99, 4'd0, 4'd0);
        send_word(ACT_CONFIG,  3'd0, 4'd5, 7'd0, 4'd0, 4'd0);
        settle();

        // Messages on ports beyond the live count are ignored, then one on a live port
        write_reg(REG_PORTS_USE, 32'd3);
        send_word(ACT_CONFIG,  3'd5, 4'd0, 7'd0, 4'd0, 4'd0);
        send_word(ACT_DATA,    3'd7, 4'd0, 7'd0, 4'd1, 4'd5);
        send_word(ACT_DATA,    3'd2, 4'd0, 7'd0, 4'd0, 4'd9);
        settle();

        // All ports live, with a long sink hold-off while words keep coming
        write_reg(REG_OWN_ID, 32'd3);
        write_reg(REG_NBR_TABLE, random_table());
        write_reg(REG_PORTS_USE, 32'd8);
        run_phase(100, 1'b1);
        hold_off_req = 1'b1;
        run_phase(24, 1'b0);
        run_phase(100, 1'b1);
        settle();

        // Lowest own id, all-ones neighbor table, single port
        write_reg(REG_OWN_ID, 32'd0);
        write_reg(REG_NBR_TABLE, 32'hFFFF_FFFF);
        write_reg(REG_PORTS_USE, 32'd1);
        run_phase(200, 1'b1);
        settle();

        // No port connected
        write_reg(REG_OWN_ID, 32'd9);
        write_reg(REG_NBR_TABLE, 32'd0);
        write_reg(REG_PORTS_USE, 32'd0);
        run_phase(40, 1'b1);
        settle();

        // Port count above the cap
        write_reg(REG_OWN_ID, 32'($urandom_range(0, 9)));
        write_reg(REG_NBR_TABLE, random_table());
        write_reg(REG_PORTS_USE, 32'd15);
        run_phase(250, 1'b1);
        settle();

        write_reg(REG_OWN_ID, 32'd9);
        write_reg(REG_NBR_TABLE, random_table());
        write_reg(REG_PORTS_USE, 32'($urandom_range(1, 8)));
        run_phase(250, 1'b1);
        settle();

        // Final stretch at full rate
        write_reg(REG_OWN_ID, 32'($urandom_range(0, 9)));
        write_reg(REG_NBR_TABLE, random_table());
        write_reg(REG_PORTS_USE, 32'd8);
        run_phase(160, 1'b0);
        settle();

        if (sb.err_count == 0) begin
            $display("spanning_tree_port_state_engine_tb: PASS");
        end else begin
            $display("spanning_tree_port_state_engine_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("spanning_tree_port_state_engine_tb: FAIL");
        $finish;
    end

endmodule
